@@ hdl/i2p_pkg.sv @@
// Shared types, character codes and the operator priority function
// for the infix-to-postfix converter. No dependencies.
`timescale 1ns / 1ps

package i2p_pkg;

	// default operator stack depth
	localparam int STACK_DEPTH_DEF = 16;

	// character codes
	localparam logic [7:0] CH_LPAR  = 8'h28; // '('
	localparam logic [7:0] CH_RPAR  = 8'h29; // ')'
	localparam logic [7:0] CH_SPACE = 8'h20; // ' '
	localparam logic [7:0] CH_CARET = 8'h5E; // '^'
	localparam logic [7:0] CH_MUL   = 8'h2A; // '*'
	localparam logic [7:0] CH_DIV   = 8'h2F; // '/'
	localparam logic [7:0] CH_ADD   = 8'h2B; // '+'
	localparam logic [7:0] CH_SUB   = 8'h2D; // '-'
	localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
	localparam logic [7:0] CH_NINE  = 8'h39; // '9'

	// priority levels
	localparam logic [1:0] PRIO_POW  = 2'd3;
	localparam logic [1:0] PRIO_MUL  = 2'd2;
	localparam logic [1:0] PRIO_ADD  = 2'd1;
	localparam logic [1:0] PRIO_NONE = 2'd0;

	// what goes into the output register
	typedef logic [2:0] emit_t;
	localparam emit_t EM_NONE  = 3'd0;
	localparam emit_t EM_SPACE = 3'd1;
	localparam emit_t EM_TOP   = 3'd2;
	localparam emit_t EM_CHAR  = 3'd3;
	localparam emit_t EM_END   = 3'd4;

	// commands from controller to datapath
	typedef struct packed {
		logic  latch;
		logic  push;
		logic  pop;
		emit_t emit;
		logic  last;
	} i2p_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_end;
		logic is_digit;
		logic is_lpar;
		logic is_rpar;
		logic cnt_zero;
		logic top_lpar;
		logic prio_le;
		logic next_more;
		logic slot_free;
	} i2p_stat_t;

	function automatic logic [1:0] prio_of(input logic [7:0] c);
		logic [1:0] p;
		begin
			p = PRIO_NONE;
			if (c == CH_CARET)
				p = PRIO_POW;
			else if (c == CH_MUL || c == CH_DIV)
				p = PRIO_MUL;
			else if (c == CH_ADD || c == CH_SUB)
				p = PRIO_ADD;
			return p;
		end
	endfunction

endpackage

@@ hdl/i2p_dpath.sv @@
// Datapath of the infix-to-postfix converter: input latch, operator stack
// with cached top entry, sticky overflow flag and output register. Uses i2p_pkg.
`timescale 1ns / 1ps

module i2p_dpath import i2p_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  i2p_cmd_t   ctl,
	output i2p_stat_t  st,
	input  logic       cmd,
	input  logic [7:0] in_char,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [7:0] out_char,
	output logic       has_char,
	output logic       last_in_run,
	output logic       expr_done,
	output logic       stack_overflow
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int IW = $clog2(STACK_DEPTH);
	localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

	logic          cmd_q;
	logic [7:0]    char_q;
	logic [7:0]    top_q;
	logic [7:0]    stk_q [STACK_DEPTH];
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [7:0]    under;
	logic          full;
	logic          ovf_out;

	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic          has_char_q;
	logic          last_q;
	logic          done_q;
	logic          ovf_o_q;

	// input latch
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q  <= cmd;
			char_q <= in_char;
		end
	end

	// stack addressing: top cached in top_q, entries below it in stk_q
	assign cnt_m1 = cnt_q - CW'(1);
	assign cnt_m2 = cnt_q - CW'(2);
	assign under  = stk_q[cnt_m2[IW-1:0]];
	assign full   = (cnt_q == FULL);

	// status decode
	always_comb begin
		st.is_end    = cmd_q;
		st.is_digit  = !cmd_q && (char_q >= CH_ZERO) && (char_q <= CH_NINE);
		st.is_lpar   = !cmd_q && (char_q == CH_LPAR);
		st.is_rpar   = !cmd_q && (char_q == CH_RPAR);
		st.cnt_zero  = (cnt_q == '0);
		st.top_lpar  = (top_q == CH_LPAR);
		st.prio_le   = (prio_of(char_q) <= prio_of(top_q));
		st.next_more = (cnt_q > CW'(1)) && (under != CH_LPAR);
		st.slot_free = !out_valid_q || !out_stall;
	end

	// stack storage, no reset
	always_ff @(posedge clk) begin
		if (ctl.push && !full) begin
			top_q <= char_q;
			if (cnt_q != '0)
				stk_q[cnt_m1[IW-1:0]] <= top_q;
		end else if (ctl.pop) begin
			top_q <= under;
		end
	end

	// stack count and sticky overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (ctl.push) begin
				if (full)
					ovf_q <= 1'b1;
				else
					cnt_q <= cnt_q + CW'(1);
			end else if (ctl.pop) begin
				cnt_q <= cnt_m1;
			end
		end
	end

	// flag as it stands once this item is done
	assign ovf_out = ovf_q || (ctl.push && full);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.emit != EM_NONE)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (ctl.emit != EM_NONE) begin
			last_q  <= ctl.last;
			ovf_o_q <= ovf_out;
			case (ctl.emit)
				EM_SPACE: begin
					out_char_q <= CH_SPACE;
					has_char_q <= 1'b1;
					done_q     <= 1'b0;
				end
				EM_TOP: begin
					out_char_q <= top_q;
					has_char_q <= 1'b1;
					done_q     <= 1'b0;
				end
				EM_CHAR: begin
					out_char_q <= char_q;
					has_char_q <= 1'b1;
					done_q     <= 1'b0;
				end
				default: begin
					out_char_q <= 8'h00;
					has_char_q <= 1'b0;
					done_q     <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign out_char       = out_char_q;
	assign has_char       = has_char_q;
	assign last_in_run    = last_q;
	assign expr_done      = done_q;
	assign stack_overflow = ovf_o_q;

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL) else $error("stack count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> cnt_q != '0) else $error("pop on empty stack");
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit != EM_NONE |-> st.slot_free) else $error("output overwritten");
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |=> ovf_q) else $error("overflow flag cleared");

endmodule

@@ hdl/i2p_ctrl.sv @@
// Controller of the infix-to-postfix converter: sequences accept, pops and
// emitted results for one item at a time. Uses i2p_pkg.
`timescale 1ns / 1ps

module i2p_ctrl import i2p_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  i2p_stat_t st,
	output i2p_cmd_t  ctl
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		ctl       = '0;
		ctl.emit  = EM_NONE;
		state_d   = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.latch = 1'b1;
					state_d   = S_RUN;
				end
			end
			S_RUN: begin
				if (st.slot_free) begin
					if (st.is_end) begin
						if (!st.cnt_zero) begin
							ctl.emit = EM_SPACE;
							state_d  = S_POP;
						end else begin
							ctl.emit = EM_END;
							ctl.last = 1'b1;
							state_d  = S_IDLE;
						end
					end else if (st.is_digit) begin
						ctl.emit = EM_CHAR;
						ctl.last = 1'b1;
						state_d  = S_IDLE;
					end else if (st.is_lpar) begin
						ctl.push = 1'b1;
						state_d  = S_IDLE;
					end else if (st.is_rpar) begin
						if (!st.cnt_zero && !st.top_lpar) begin
							ctl.emit = EM_SPACE;
							state_d  = S_POP;
						end else begin
							// drop the matching '(' silently
							ctl.pop = !st.cnt_zero;
							state_d = S_IDLE;
						end
					end else begin
						if (!st.cnt_zero && st.prio_le) begin
							ctl.emit = EM_SPACE;
							state_d  = S_POP;
						end else begin
							ctl.emit = EM_SPACE;
							ctl.last = 1'b1;
							ctl.push = 1'b1;
							state_d  = S_IDLE;
						end
					end
				end
			end
			S_POP: begin
				if (st.slot_free) begin
					ctl.emit = EM_TOP;
					ctl.pop  = 1'b1;
					// only a closing paren can end its run on a popped operator
					ctl.last = st.is_rpar && !st.next_more;
					state_d  = S_RUN;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// checks
	a_latch_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.latch |-> state_q == S_IDLE) else $error("latch outside idle");
	a_pop_emits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP && st.slot_free |-> ctl.pop && ctl.emit == EM_TOP)
		else $error("pop state without pop");
	a_push_ends: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |=> state_q == S_IDLE) else $error("push not closing item");

endmodule

@@ hdl/infix_to_postfix_converter.sv @@
// Top level of the infix-to-postfix converter: controller plus datapath.
// Depends on i2p_pkg, i2p_ctrl and i2p_dpath.
//
// Input channel (in_valid / in_stall): cmd = 0 carries one expression character
// in in_char, cmd = 1 ends the expression and flushes the operator stack.
// Output channel (out_valid / out_stall): one postfix character per result, with
// has_char, last_in_run (final result of the input item), expr_done (end marker
// of a flush) and the sticky stack_overflow flag.
// One input item is handled at a time: the controller latches it in S_IDLE,
// then emits its results from S_RUN and S_POP. Each popped operator is sent as
// a space (S_RUN) then the operator (S_POP); a digit is copied out, a plain
// operator push emits a space, '(' and a ')' that drops its '(' emit nothing.
// Results leave through a single output register; while it holds a result and
// out_stall is high the controller waits. in_stall stays high until the current
// item is done. Reset empties the stack, clears the overflow flag and out_valid.
`timescale 1ns / 1ps

module infix_to_postfix_converter import i2p_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd,
	input  logic [7:0] in_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       has_char,
	output logic       last_in_run,
	output logic       expr_done,
	output logic       stack_overflow
);

	i2p_cmd_t  ctl;
	i2p_stat_t st;

	i2p_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.ctl      (ctl)
	);

	i2p_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.st             (st),
		.cmd            (cmd),
		.in_char        (in_char),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.out_char       (out_char),
		.has_char       (has_char),
		.last_in_run    (last_in_run),
		.expr_done      (expr_done),
		.stack_overflow (stack_overflow)
	);

endmodule
